>>> hw/rtl/sha1_pkg.sv
package sha1_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_vars_t;

  localparam int BLOCK_BITS = 512;
  localparam int ROUNDS     = 80;
  localparam int DIGEST_WDS = 5;

  localparam sha1_vars_t H_INIT = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

>>> hw/rtl/sha1_round.sv
module sha1_round (
  input  sha1_pkg::sha1_vars_t        vars,
  input  logic [6:0]                  rnd,
  input  logic [sha1_pkg::BLOCK_BITS-1:0] sched,
  output sha1_pkg::sha1_vars_t        vars_nxt,
  output logic [sha1_pkg::BLOCK_BITS-1:0] sched_nxt
);
  import sha1_pkg::*;

  logic [31:0] w0, w2, w8, w13, w_new, f, k, tmp;

  // schedule line holds w[t..t+15], w[t] in the top word
  assign w0  = sched[BLOCK_BITS-1    -: 32];
  assign w2  = sched[BLOCK_BITS-1-64 -: 32];
  assign w8  = sched[BLOCK_BITS-1-256 -: 32];
  assign w13 = sched[BLOCK_BITS-1-416 -: 32];

  always_comb begin
    w_new = w13 ^ w8 ^ w2 ^ w0;
    w_new = {w_new[30:0], w_new[31]};
    if (rnd < 7'd20) begin
      f = (vars.b & vars.c) | (~vars.b & vars.d);
      k = K_0;
    end else if (rnd < 7'd40) begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K_1;
    end else if (rnd < 7'd60) begin
      f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
      k = K_2;
    end else begin
      f = vars.b ^ vars.c ^ vars.d;
      k = K_3;
    end
    tmp = {vars.a[26:0], vars.a[31:27]} + f + vars.e + k + w0;
    vars_nxt.a = tmp;
    vars_nxt.b = vars.a;
    vars_nxt.c = {vars.b[1:0], vars.b[31:2]};
    vars_nxt.d = vars.c;
    vars_nxt.e = vars.d;
    sched_nxt  = {sched[BLOCK_BITS-33:0], w_new};
  end

endmodule

>>> hw/rtl/sha1_stream_hash.sv
// SHA-1 over a byte stream. Each input transaction carries one message byte
// (in_tuser high) and/or marks the end of the message (in_tlast high). The
// byte that completes a 64-byte block is followed by a busy period (80 rounds
// through one shared round unit, then the chaining add). An end transaction
// pads one byte per cycle up to the length field, appends the 8 length bytes
// one per cycle, compresses one or two blocks and then presents the digest as
// five output transactions, word 0 first, out_tlast on word 4. in_tready is
// low while the block finished by a block-completing byte is compressed, and
// from an end marker until the last digest word is taken, after which the
// hash state is back at its initial values.
module sha1_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] message_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            st_r, st_nxt;
  logic [5:0]            pos_r, pos_nxt;
  logic [63:0]           len_r, len_nxt;
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  sha1_vars_t            h_r, h_nxt;
  sha1_vars_t            v_r, v_nxt;
  logic [6:0]            rnd_r, rnd_nxt;
  logic                  fin_r, fin_nxt;
  logic                  lenblk_r, lenblk_nxt;
  logic                  mark_r, mark_nxt;
  logic [2:0]            oidx_r, oidx_nxt;

  sha1_vars_t            v_rnd;
  logic [BLOCK_BITS-1:0] blk_rnd;
  logic [7:0]            len_byte;

  sha1_round u_round (
    .vars      (v_r),
    .rnd       (rnd_r),
    .sched     (blk_r),
    .vars_nxt  (v_rnd),
    .sched_nxt (blk_rnd)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = h_r.a;
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'(DIGEST_WDS - 1));

  // big-endian length byte for block position 56 + k
  assign len_byte = len_r[{~pos_r[2:0], 3'b111} -: 8];

  always_comb begin
    st_nxt     = st_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    blk_nxt    = blk_r;
    h_nxt      = h_r;
    v_nxt      = v_r;
    rnd_nxt    = rnd_r;
    fin_nxt    = fin_r;
    lenblk_nxt = lenblk_r;
    mark_nxt   = mark_r;
    oidx_nxt   = oidx_r;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid && (in_tuser || in_tlast)) begin
          fin_nxt  = in_tlast;
          mark_nxt = 1'b1;
          if (in_tuser) begin
            blk_nxt = {blk_r[BLOCK_BITS-9:0], in_tdata};
            len_nxt = len_r + 64'd8;
            pos_nxt = pos_r + 6'd1;
          end
          if (in_tuser && pos_r == 6'd63) begin
            st_nxt  = S_RND;
            v_nxt   = h_r;
            rnd_nxt = '0;
          end else if (in_tlast) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        blk_nxt  = {blk_r[BLOCK_BITS-9:0], (mark_r ? PAD_MARK : 8'h00)};
        mark_nxt = 1'b0;
        pos_nxt  = pos_r + 6'd1;
        if (pos_r == 6'd55) begin
          st_nxt = S_LEN;
        end else if (pos_r == 6'd63) begin
          st_nxt  = S_RND;
          v_nxt   = h_r;
          rnd_nxt = '0;
        end
      end
      S_LEN: begin
        blk_nxt = {blk_r[BLOCK_BITS-9:0], len_byte};
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          st_nxt     = S_RND;
          lenblk_nxt = 1'b1;
          v_nxt      = h_r;
          rnd_nxt    = '0;
        end
      end
      S_RND: begin
        v_nxt   = v_rnd;
        blk_nxt = blk_rnd;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUNDS - 1)) begin
          st_nxt = S_ADD;
        end
      end
      S_ADD: begin
        h_nxt.a = h_r.a + v_r.a;
        h_nxt.b = h_r.b + v_r.b;
        h_nxt.c = h_r.c + v_r.c;
        h_nxt.d = h_r.d + v_r.d;
        h_nxt.e = h_r.e + v_r.e;
        if (lenblk_r) begin
          st_nxt   = S_OUT;
          oidx_nxt = '0;
        end else if (fin_r) begin
          st_nxt = S_PAD;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          // rotate so the next word sits in the a slot
          h_nxt    = {h_r.b, h_r.c, h_r.d, h_r.e, h_r.a};
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'(DIGEST_WDS - 1)) begin
            st_nxt     = S_IDLE;
            h_nxt      = H_INIT;
            len_nxt    = '0;
            pos_nxt    = '0;
            fin_nxt    = 1'b0;
            lenblk_nxt = 1'b0;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pos_r    <= '0;
      len_r    <= '0;
      h_r      <= H_INIT;
      rnd_r    <= '0;
      fin_r    <= 1'b0;
      lenblk_r <= 1'b0;
      mark_r   <= 1'b0;
      oidx_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      h_r      <= h_nxt;
      rnd_r    <= rnd_nxt;
      fin_r    <= fin_nxt;
      lenblk_r <= lenblk_nxt;
      mark_r   <= mark_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
  end

endmodule

>>> sim/sha1_stream_hash_tb.sv
`timescale 1ns / 100ps

module sha1_stream_hash_tb;
  import sha1_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int RANDOM_ITEMS   = 280;
  localparam int MIN_MESSAGES   = 9;
  localparam int IDLE_PCT       = 22;
  localparam int HOLD_AFTER     = 50;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 250;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  localparam int N_DIRECTED = 15;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // empty message straight after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    // last byte travels with the end marker
    '{8'h63, 1'b1, 1'b1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'hA5, 1'b1, 1'b0, 1'b0, 160'h0},
    // pure end marker, data byte ignored
    '{8'h5A, 1'b0, 1'b1, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h7F, 1'b1, 1'b1, 1'b0, 160'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // hash state mirrored on the testbench side
  logic [31:0]  chain_h [DIGEST_WDS];
  logic [7:0]   block_buf [64];
  logic [63:0]  msg_bits;
  logic [31:0]  digest_words [DIGEST_WDS];
  digest_beat_t pending_words [$];

  int errors     = 0;
  int words_seen = 0;
  int items_sent = 0;
  bit steady     = 1'b0;

  sha1_stream_hash u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void load_chain();
    chain_h[0] = H_INIT.a;
    chain_h[1] = H_INIT.b;
    chain_h[2] = H_INIT.c;
    chain_h[3] = H_INIT.d;
    chain_h[4] = H_INIT.e;
    msg_bits   = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int s;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < ROUNDS; r++) begin
      s = r % 16;
      // rolling schedule: overwrite the slot sixteen rounds old
      if (r >= 16)
        w[s] = rotl(w[(s+13)%16] ^ w[(s+8)%16] ^ w[(s+2)%16] ^ w[s], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      t = rotl(a, 5) + f + e + k + w[s];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // returns 1 when the transaction finishes a message and digest_words is filled
  function automatic bit absorb_item(input logic [7:0] data, input logic present,
                                     input logic eom);
    int pos;
    logic [63:0] len;
    if (present) begin
      pos = int'(msg_bits[8:3]);
      block_buf[pos] = data;
      msg_bits += 64'd8;
      if (pos == 63) compress_block();
    end
    if (!eom) return 1'b0;
    len = msg_bits;
    pos = int'(len[8:3]);
    block_buf[pos] = PAD_MARK;
    for (int i = pos + 1; i < 64; i++) block_buf[i] = 8'h00;
    // no room for the length field, so pad out an extra block
    if (pos >= 56) begin
      compress_block();
      for (int i = 0; i < 56; i++) block_buf[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) block_buf[56+i] = len[8*(7-i) +: 8];
    compress_block();
    for (int i = 0; i < DIGEST_WDS; i++) digest_words[i] = chain_h[i];
    load_chain();
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] data, input logic present, input logic eom,
                           input logic known, input logic [159:0] known_digest);
    digest_beat_t beat;
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = data;
    in_tuser  = present;
    in_tlast  = eom;
    do @(posedge clk); while (!in_tready);
    if (present || eom) items_sent++;
    if (absorb_item(data, present, eom)) begin
      for (int i = 0; i < DIGEST_WDS; i++) begin
        beat.word  = known ? known_digest[159 - 32*i -: 32] : digest_words[i];
        beat.index = 3'(i);
        beat.last  = (i == DIGEST_WDS - 1);
        pending_words.push_back(beat);
      end
    end
  endtask

  task automatic wait_for_digests();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_words.size() == 0);
  endtask

  initial begin : stimulus
    int len;
    int messages;
    bit end_with_byte;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    load_chain();
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED[i].data, DIRECTED[i].present, DIRECTED[i].eom,
                DIRECTED[i].known, DIRECTED[i].digest);
    wait_for_digests();

    messages = 0;
    while (items_sent < RANDOM_ITEMS || messages < MIN_MESSAGES) begin
      steady = (messages >= 2 && messages <= 4);
      // bias lengths towards the one-block / two-block padding boundary
      case ($urandom_range(11))
        0:       len = 55;
        1:       len = 56;
        2:       len = $urandom_range(63, 64);
        3:       len = $urandom_range(119, 129);
        default: len = $urandom_range(20);
      endcase
      end_with_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int j = 0; j < len - int'(end_with_byte); j++) begin
        if ($urandom_range(19) == 0)
          send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        send_item(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
      end
      send_item(8'($urandom), end_with_byte, 1'b1, 1'b0, '0);
      messages++;
      if ($urandom_range(6) == 0) wait_for_digests();
    end
    steady = 1'b0;

    wait_for_digests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("sha1_stream_hash_tb OK");
    else $display("sha1_stream_hash_tb NOT OK");
    $finish;
  end

  initial begin : sink_ready
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!hold_done && words_seen >= HOLD_AFTER) begin
        // long back-pressure so the input side stalls behind the digest
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : digest_check
    digest_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected transaction: digest_word %h word_index %0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_tdata !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, out_tdata);
          errors++;
        end
        if (out_tuser !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, out_tuser);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_word: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < TIMEOUT_CYCLES; cycles++) @(posedge clk);
    $display("sha1_stream_hash_tb NOT OK");
    $finish;
  end

endmodule

>>> sha1_stream_hash.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_round.sv
hw/rtl/sha1_stream_hash.sv
sim/sha1_stream_hash_tb.sv
